// ===== rtl/mdg_pkg.sv =====
// ----------------------------------------------------------------------------
// mdg_pkg
// Shared types and constants of the depth-first maze generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mdg_pkg;

  // Grid coordinates, configuration data and result fields are all 6 bits.
  localparam int unsigned POS_W = 6;

  // Width of the start-epoch mark that the visited map stores per room.
  localparam int unsigned EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;
  localparam logic [POS_W-1:0] GRID_RESET = 6'd45;

  // Item kinds carried on the input tuser.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    DIR_NORTH,
    DIR_SOUTH,
    DIR_EAST,
    DIR_WEST
  } dir_e;

  // Result payload, first member in the highest bits.
  typedef struct packed {
    logic [POS_W-1:0] wall_col;
    logic [POS_W-1:0] wall_row;
    logic [POS_W-1:0] pos_col;
    logic [POS_W-1:0] pos_row;
  } res_t;

  typedef struct packed {
    logic done_res;
    logic backtracked;
    logic carved;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/mdg_visit_ram.sv =====
// ----------------------------------------------------------------------------
// mdg_visit_ram
// Visited map storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mdg_visit_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mdg_stack_ram.sv =====
// ----------------------------------------------------------------------------
// mdg_stack_ram
// Backtrack stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mdg_stack_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/maze_dfs_generator_top.sv =====
// ----------------------------------------------------------------------------
// maze_dfs_generator_top
// Randomized depth-first maze carver with a memory-resident visited map and
// backtrack stack.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction. A step item
// passes through the accepting cycle, which issues the north/south visited
// reads, an S_RD cycle for the east/west reads, and a decision cycle, where its
// result is registered. The visited map has two read ports and four neighbors
// are checked, which is why the reads are split into two pairs. A start item
// goes from acceptance straight to the decision cycle, where its result is
// registered. The decision cycle stalls while the previous result still waits
// in the output register. Instead of clearing the visited map on every start,
// each start advances a 4-bit epoch and a room counts as visited when its
// stored mark equals the current epoch. After reset, and on every fifteenth
// start when the epoch wraps, a clearing pass runs over all rooms,
// ((MAX_ROWS+1)/2)*((MAX_COLS+1)/2) of them (1024 by default), with the
// input stalled; configuration writes are accepted throughout. A finished
// result waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_dfs_generator_top #(
  parameter int unsigned MAX_ROWS    = 63,
  parameter int unsigned MAX_COLS    = 63,
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mdg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mdg_pkg::POS_W-1:0]          cfg_data_i,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mdg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [1:0] random_dir
  input  logic [0:0]                         s_axis_tuser,  // [0] kind
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] pos_row, [11:6] pos_col, [17:12] wall_row, [23:18] wall_col
  output logic [mdg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] carved, [1] backtracked, [2] done_res
  output logic [mdg_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

  localparam int unsigned RoomsPerRow = (MAX_COLS + 1) / 2;
  localparam int unsigned RoomsPerCol = (MAX_ROWS + 1) / 2;
  localparam int unsigned RoomCount   = RoomsPerRow * RoomsPerCol;
  localparam int unsigned IdxW        = $clog2(RoomCount);
  localparam int unsigned RowRoomW    = $clog2(RoomsPerCol);
  localparam int unsigned ColRoomW    = $clog2(RoomsPerRow);
  localparam int unsigned StackW      = RowRoomW + ColRoomW;
  localparam int unsigned SpW         = $clog2(STACK_DEPTH);
  localparam int unsigned CntW        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW          = mdg_pkg::POS_W;
  localparam int unsigned EW          = mdg_pkg::EPOCH_W;

  localparam logic [CntW-1:0] StackFull = CntW'(STACK_DEPTH);
  localparam logic [7:0]      MaxRowsW  = 8'(MAX_ROWS);
  localparam logic [7:0]      MaxColsW  = 8'(MAX_COLS);
  localparam logic [IdxW-1:0] LastRoom  = IdxW'(RoomCount - 1);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_DEC
  } state_e;

  function automatic logic [IdxW-1:0] room_idx(input logic [PW-1:0] r,
                                               input logic [PW-1:0] c);
    room_idx = IdxW'((r >> 1) * RoomsPerRow + (c >> 1));
  endfunction

  state_e              state_q;
  logic [IdxW-1:0]     clr_idx_q;
  logic                init_done_q;
  logic [EW-1:0]       epoch_q;
  logic [PW-1:0]       grid_rows_q, grid_cols_q;
  logic [PW-1:0]       cur_row_q, cur_col_q;
  logic [CntW-1:0]     stack_cnt_q;
  logic                finished_q;
  logic                kind_q;
  mdg_pkg::dir_e       dir_q;
  logic [1:0]          free_q;
  logic                out_valid_q;
  mdg_pkg::res_t       res_q;
  mdg_pkg::flags_t     flags_q;

  logic [PW-1:0]       rows_raw, cols_raw, rows, cols;
  logic [PW-1:0]       nr [4];
  logic [PW-1:0]       nc [4];
  logic [PW-1:0]       wr [4];
  logic [PW-1:0]       wc [4];
  logic [IdxW-1:0]     nb_idx [4];
  logic [IdxW-1:0]     cur_idx;
  logic [3:0]          bnd, free, avail;
  logic                full, do_carve, no_move, do_pop, do_finish;
  logic                is_start, wrap, out_free, commit;

  logic                vis_we;
  logic [IdxW-1:0]     vis_waddr, vis_raddr_a, vis_raddr_b;
  logic [EW-1:0]       vis_wdata, vis_rdata_a, vis_rdata_b;
  logic                stk_we;
  logic [SpW-1:0]      stk_waddr, stk_raddr;
  logic [StackW-1:0]   stk_wdata, stk_rdata;
  logic [PW-1:0]       pop_row, pop_col;

  logic [PW-1:0]       nxt_row, nxt_col;
  logic [CntW-1:0]     nxt_cnt;
  logic                nxt_fin;
  logic [PW-1:0]       nxt_wall_r, nxt_wall_c;
  mdg_pkg::flags_t     nxt_flags;

  // Grid size in use: bit zero forced, then limited to the parameter.
  assign rows_raw = grid_rows_q | PW'(1);
  assign cols_raw = grid_cols_q | PW'(1);
  assign rows = ({2'b00, rows_raw} > MaxRowsW) ? MaxRowsW[PW-1:0] : rows_raw;
  assign cols = ({2'b00, cols_raw} > MaxColsW) ? MaxColsW[PW-1:0] : cols_raw;

  always_comb begin
    nr[mdg_pkg::DIR_NORTH] = cur_row_q - PW'(2);
    nc[mdg_pkg::DIR_NORTH] = cur_col_q;
    nr[mdg_pkg::DIR_SOUTH] = cur_row_q + PW'(2);
    nc[mdg_pkg::DIR_SOUTH] = cur_col_q;
    nr[mdg_pkg::DIR_EAST]  = cur_row_q;
    nc[mdg_pkg::DIR_EAST]  = cur_col_q + PW'(2);
    nr[mdg_pkg::DIR_WEST]  = cur_row_q;
    nc[mdg_pkg::DIR_WEST]  = cur_col_q - PW'(2);
    wr[mdg_pkg::DIR_NORTH] = cur_row_q - PW'(1);
    wc[mdg_pkg::DIR_NORTH] = cur_col_q;
    wr[mdg_pkg::DIR_SOUTH] = cur_row_q + PW'(1);
    wc[mdg_pkg::DIR_SOUTH] = cur_col_q;
    wr[mdg_pkg::DIR_EAST]  = cur_row_q;
    wc[mdg_pkg::DIR_EAST]  = cur_col_q + PW'(1);
    wr[mdg_pkg::DIR_WEST]  = cur_row_q;
    wc[mdg_pkg::DIR_WEST]  = cur_col_q - PW'(1);
  end

  // A southern or eastern room fits when pos + 2 <= size - 2.
  assign bnd[mdg_pkg::DIR_NORTH] = cur_row_q >= PW'(3);
  assign bnd[mdg_pkg::DIR_SOUTH] = ({1'b0, cur_row_q} + 7'd4) <= {1'b0, rows};
  assign bnd[mdg_pkg::DIR_EAST]  = ({1'b0, cur_col_q} + 7'd4) <= {1'b0, cols};
  assign bnd[mdg_pkg::DIR_WEST]  = cur_col_q >= PW'(3);

  assign cur_idx = room_idx(cur_row_q, cur_col_q);

  // Out-of-border neighbors read the current room so the address stays valid.
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nb_idx[d] = bnd[d] ? room_idx(nr[d], nc[d]) : cur_idx;
    end
  end

  // North/south are read while the item is accepted, east/west in the following cycle.
  assign vis_raddr_a = (state_q == S_IDLE) ? nb_idx[mdg_pkg::DIR_NORTH]
                                           : nb_idx[mdg_pkg::DIR_EAST];
  assign vis_raddr_b = (state_q == S_IDLE) ? nb_idx[mdg_pkg::DIR_SOUTH]
                                           : nb_idx[mdg_pkg::DIR_WEST];

  assign free[mdg_pkg::DIR_NORTH] = free_q[0];
  assign free[mdg_pkg::DIR_SOUTH] = free_q[1];
  assign free[mdg_pkg::DIR_EAST]  = vis_rdata_a != epoch_q;
  assign free[mdg_pkg::DIR_WEST]  = vis_rdata_b != epoch_q;

  assign full      = stack_cnt_q >= StackFull;
  assign avail     = bnd & free & {4{~full}};
  assign do_carve  = avail[dir_q];
  assign no_move   = avail == 4'b0000;
  assign do_pop    = no_move && (stack_cnt_q != '0);
  assign do_finish = no_move && (stack_cnt_q == '0);

  assign is_start  = kind_q == mdg_pkg::KIND_START;
  assign wrap      = is_start && (epoch_q == mdg_pkg::EPOCH_MAX);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign commit    = (state_q == S_DEC) && out_free && !wrap;

  // The stack top is read continuously; the count only moves on a commit.
  assign stk_raddr = (stack_cnt_q == '0) ? '0 : SpW'(stack_cnt_q - CntW'(1));
  assign pop_row   = PW'({stk_rdata[StackW-1:ColRoomW], 1'b1});
  assign pop_col   = PW'({stk_rdata[ColRoomW-1:0], 1'b1});

  always_comb begin
    nxt_row    = cur_row_q;
    nxt_col    = cur_col_q;
    nxt_cnt    = stack_cnt_q;
    nxt_fin    = finished_q;
    nxt_wall_r = '0;
    nxt_wall_c = '0;
    nxt_flags  = '0;
    priority if (is_start) begin
      nxt_row = PW'(1);
      nxt_col = PW'(1);
      nxt_cnt = '0;
      nxt_fin = 1'b0;
    end else if (do_carve) begin
      nxt_row         = nr[dir_q];
      nxt_col         = nc[dir_q];
      nxt_cnt         = stack_cnt_q + CntW'(1);
      nxt_wall_r      = wr[dir_q];
      nxt_wall_c      = wc[dir_q];
      nxt_flags.carved = 1'b1;
    end else if (do_pop) begin
      nxt_row              = pop_row;
      nxt_col              = pop_col;
      nxt_cnt              = stack_cnt_q - CntW'(1);
      nxt_flags.backtracked = 1'b1;
    end else if (do_finish) begin
      nxt_cnt = '0;
      nxt_fin = 1'b1;
    end else begin
      nxt_cnt = stack_cnt_q;
    end
    nxt_flags.done_res = nxt_fin;
  end

  assign vis_we    = (state_q == S_CLR) || (commit && (is_start || do_carve));
  assign vis_waddr = (state_q == S_CLR) ? clr_idx_q
                   : (is_start ? room_idx(PW'(1), PW'(1)) : nb_idx[dir_q]);
  assign vis_wdata = (state_q == S_CLR) ? '0
                   : (is_start ? epoch_q + EW'(1) : epoch_q);

  assign stk_we    = commit && !is_start && do_carve;
  assign stk_waddr = SpW'(stack_cnt_q);
  assign stk_wdata = {RowRoomW'(cur_row_q >> 1), ColRoomW'(cur_col_q >> 1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_idx_q   <= '0;
      init_done_q <= 1'b0;
      epoch_q     <= EW'(1);
      grid_rows_q <= mdg_pkg::GRID_RESET;
      grid_cols_q <= mdg_pkg::GRID_RESET;
      cur_row_q   <= PW'(1);
      cur_col_q   <= PW'(1);
      stack_cnt_q <= '0;
      finished_q  <= 1'b0;
      kind_q      <= mdg_pkg::KIND_START;
      dir_q       <= mdg_pkg::DIR_NORTH;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mdg_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          mdg_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        endcase
      end

      if (m_axis_tready && !commit) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLR: begin
          if (clr_idx_q == LastRoom) begin
            clr_idx_q   <= '0;
            init_done_q <= 1'b1;
            // A pass started by an epoch wrap resumes the pending start item.
            if (init_done_q) begin
              epoch_q <= '0;
              state_q <= S_DEC;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            clr_idx_q <= clr_idx_q + IdxW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q  <= s_axis_tuser[0];
            dir_q   <= mdg_pkg::dir_e'(s_axis_tdata[1:0]);
            state_q <= (s_axis_tuser[0] == mdg_pkg::KIND_START) ? S_DEC : S_RD;
          end
        end
        S_RD: begin
          free_q  <= {vis_rdata_b != epoch_q, vis_rdata_a != epoch_q};
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (wrap) begin
            state_q <= S_CLR;
          end else if (out_free) begin
            if (is_start) begin
              epoch_q <= epoch_q + EW'(1);
            end
            cur_row_q   <= nxt_row;
            cur_col_q   <= nxt_col;
            stack_cnt_q <= nxt_cnt;
            finished_q  <= nxt_fin;
            out_valid_q <= 1'b1;
            res_q       <= '{wall_col: nxt_wall_c, wall_row: nxt_wall_r,
                             pos_col: nxt_col, pos_row: nxt_row};
            flags_q     <= nxt_flags;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  mdg_visit_ram #(
    .DEPTH (RoomCount),
    .WIDTH (EW)
  ) u_visit_ram (
    .clk_i     (clk_i),
    .we_i      (vis_we),
    .waddr_i   (vis_waddr),
    .wdata_i   (vis_wdata),
    .raddr_a_i (vis_raddr_a),
    .raddr_b_i (vis_raddr_b),
    .rdata_a_o (vis_rdata_a),
    .rdata_b_o (vis_rdata_b)
  );

  mdg_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (StackW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = flags_q;

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_cnt_q <= StackFull)
    else $error("stack count exceeds the stack depth");

  a_room_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_row_q[0] && cur_col_q[0])
    else $error("walker left the odd room grid");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (epoch_q != '0))
    else $error("idle with the reserved epoch value");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |=> (stack_cnt_q == $past(stack_cnt_q) + CntW'(1)))
    else $error("push did not advance the stack count");

  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(flags_q.carved && flags_q.backtracked))
    else $error("result reports both a carve and a backtrack");
`endif

endmodule

`default_nettype wire
